FILE: sv/cnaf_pkg.sv
`default_nettype none

package cnaf_pkg;

    // Largest supported image side.
    localparam int MAX_WIDTH    = 1024;
    localparam int WIDTH_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int EXT_BITS     = WIDTH_BITS + 1;
    localparam int SLOT_DEPTH   = 2 * MAX_WIDTH;
    localparam int SLOT_BITS    = $clog2(SLOT_DEPTH);

    localparam int CFG_BITS     = 11;
    localparam int POS_BITS     = 10;
    localparam int PIX_BITS     = 8;

    // 5 * 255 fits in 11 bits
    localparam int SUM_BITS     = 11;
    localparam int RECIP_BITS   = 12;
    localparam int SHIFT_BITS   = 4;
    localparam int PROD_BITS    = SUM_BITS + RECIP_BITS;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_BITS   = 3;
    localparam logic [PADDR_BITS-3:0] REG_IMAGE_WIDTH = '0;
    localparam logic [CFG_BITS-1:0]   WIDTH_RESET     = 11'd256;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                op;
        logic [PIX_BITS-1:0] pixel;
    } cnaf_in_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] smoothed;
        logic [POS_BITS-1:0] col;
        logic [POS_BITS-1:0] row;
        logic                frame_end;
    } cnaf_out_t;

    // One classified item handed from front to back.
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot_c;
        logic [SLOT_BITS-1:0] slot_l;
        logic [SLOT_BITS-1:0] slot_r;
        logic [SLOT_BITS-1:0] slot_u;
        logic                 has_l;
        logic                 has_r;
        logic                 has_u;
        logic                 has_d;
        logic                 emit;
        logic                 wr;
        logic [PIX_BITS-1:0]  pixel;
        logic [POS_BITS-1:0]  col;
        logic [POS_BITS-1:0]  row;
        logic                 frame_end;
    } cnaf_job_t;

    typedef struct packed {
        logic [RECIP_BITS-1:0] recip;
        logic [SHIFT_BITS-1:0] shift;
    } cnaf_div_t;

    function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [CFG_BITS-1:0] v);
        logic [WIDTH_BITS-1:0] w;
        if (v == '0)
            w = WIDTH_BITS'(1);
        else if (int'(v) > MAX_WIDTH)
            w = WIDTH_BITS'(MAX_WIDTH);
        else
            w = WIDTH_BITS'(v);
        return w;
    endfunction

    // Reciprocal and shift for an exact floor(sum / pts), sum <= 1275.
    function automatic cnaf_div_t div_of(input logic [2:0] pts);
        cnaf_div_t d;
        case (pts)
            3'd3:    d = '{recip: 12'd683,  shift: 4'd11};
            3'd4:    d = '{recip: 12'd1,    shift: 4'd2};
            3'd5:    d = '{recip: 12'd3277, shift: 4'd14};
            3'd2:    d = '{recip: 12'd1,    shift: 4'd1};
            default: d = '{recip: 12'd1,    shift: 4'd0};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cnaf_ram.sv
`default_nettype none

module cnaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/cnaf_queue.sv
`default_nettype none

module cnaf_queue import cnaf_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cnaf_job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output logic           nonempty,
    output cnaf_job_t      head
);

    cnaf_job_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wptr_reg, wptr_next;
    logic [QPTR_BITS-1:0]   rptr_reg, rptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slots_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("item pushed into a full queue");

endmodule

`default_nettype wire

FILE: sv/cnaf_front.sv
`default_nettype none

module cnaf_front import cnaf_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr,
    input  wire logic [WIDTH_BITS-1:0] width,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire cnaf_in_t              in_data,
    output logic                       push,
    output cnaf_job_t                  job,
    input  wire logic                  q_full
);

    // Counters track the next incoming position n: column, row, ring slot.
    logic [WIDTH_BITS-1:0] ncol_reg, ncol_next;
    logic [WIDTH_BITS-1:0] nrow_reg, nrow_next;
    logic [SLOT_BITS-1:0]  nslot_reg, nslot_next;
    logic                  draining_reg, draining_next;

    logic                  acc;
    logic                  is_pixel;
    logic                  is_drain;
    logic                  last_col;
    logic [EXT_BITS-1:0]   w_ext, w2, ns_ext, c_ext, l_ext, r_ext, nsn_ext;

    assign in_ready = !q_full;

    always_comb
    begin
        acc      = in_valid && !q_full;
        is_pixel = (in_data.op == OP_PIXEL) && !draining_reg;
        is_drain = (in_data.op == OP_DRAIN) && draining_reg;
        last_col = (ncol_reg == width - 1'b1);

        w_ext   = EXT_BITS'(width);
        w2      = w_ext << 1;
        ns_ext  = EXT_BITS'(nslot_reg);
        // result position is n - w
        c_ext   = (ns_ext >= w_ext) ? ns_ext - w_ext : ns_ext + w_ext;
        l_ext   = (c_ext == '0) ? w2 - 1'b1 : c_ext - 1'b1;
        r_ext   = (c_ext + 1'b1 == w2) ? '0 : c_ext + 1'b1;
        nsn_ext = (ns_ext + 1'b1 == w2) ? '0 : ns_ext + 1'b1;

        job.slot_c    = SLOT_BITS'(c_ext);
        job.slot_l    = SLOT_BITS'(l_ext);
        job.slot_r    = SLOT_BITS'(r_ext);
        job.slot_u    = nslot_reg;
        job.has_l     = (ncol_reg != '0);
        job.has_r     = !last_col;
        job.has_u     = (nrow_reg > WIDTH_BITS'(1));
        job.has_d     = is_pixel;
        job.emit      = is_drain || (nrow_reg != '0);
        job.wr        = is_pixel;
        job.pixel     = in_data.pixel;
        job.col       = POS_BITS'(ncol_reg);
        job.row       = POS_BITS'(nrow_reg - 1'b1);
        job.frame_end = (nrow_reg == width) && last_col;

        push = acc && (is_pixel || is_drain);

        ncol_next     = ncol_reg;
        nrow_next     = nrow_reg;
        nslot_next    = nslot_reg;
        draining_next = draining_reg;
        if (cfg_wr)
        begin
            ncol_next     = '0;
            nrow_next     = '0;
            nslot_next    = '0;
            draining_next = 1'b0;
        end
        else if (push)
        begin
            nslot_next = SLOT_BITS'(nsn_ext);
            ncol_next  = last_col ? '0 : ncol_reg + 1'b1;
            if (is_pixel && last_col)
            begin
                nrow_next = nrow_reg + 1'b1;
                if (nrow_reg + 1'b1 == width)
                begin
                    draining_next = 1'b1;
                end
            end
            if (is_drain && last_col)
            begin
                // last row drained: next frame starts at position zero
                nrow_next     = '0;
                nslot_next    = '0;
                draining_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncol_reg     <= '0;
            nrow_reg     <= '0;
            nslot_reg    <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            ncol_reg     <= ncol_next;
            nrow_reg     <= nrow_next;
            nslot_reg    <= nslot_next;
            draining_reg <= draining_next;
        end
    end

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ncol_reg < width)
        else $error("column counter beyond image width");

    a_drain_row: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (nrow_reg == width))
        else $error("drain phase without a complete frame");

endmodule

`default_nettype wire

FILE: sv/cnaf_back.sv
`default_nettype none

module cnaf_back import cnaf_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_nonempty,
    input  wire cnaf_job_t q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output cnaf_out_t      out_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD_C  = 3'd1;
    localparam logic [2:0] ST_RD_L  = 3'd2;
    localparam logic [2:0] ST_RD_R  = 3'd3;
    localparam logic [2:0] ST_RD_U  = 3'd4;
    localparam logic [2:0] ST_ACC_U = 3'd5;
    localparam logic [2:0] ST_MUL   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]            state_reg, state_next;
    cnaf_job_t             job_reg, job_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [SHIFT_BITS-1:0] shift_reg, shift_next;
    logic                  out_valid_reg, out_valid_next;
    cnaf_out_t             out_data_reg, out_data_next;

    logic                  ram_we;
    logic [SLOT_BITS-1:0]  raddr;
    logic [PIX_BITS-1:0]   rdata;
    logic [2:0]            pts;
    cnaf_div_t             div;
    logic [PROD_BITS-1:0]  quot;

    cnaf_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (SLOT_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (job_reg.slot_u),
        .wdata (job_reg.pixel),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        pts  = 3'd1 + {2'b0, job_reg.has_l} + {2'b0, job_reg.has_r}
                    + {2'b0, job_reg.has_u} + {2'b0, job_reg.has_d};
        div  = div_of(pts);
        quot = prod_reg >> shift_reg;

        state_next     = state_reg;
        job_next       = job_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        raddr          = job_reg.slot_c;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_nonempty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_head;
                    state_next = ST_RD_C;
                end
            end
            ST_RD_C:
            begin
                raddr      = job_reg.slot_c;
                state_next = ST_RD_L;
            end
            ST_RD_L:
            begin
                raddr      = job_reg.slot_l;
                sum_next   = SUM_BITS'(rdata);
                state_next = ST_RD_R;
            end
            ST_RD_R:
            begin
                raddr    = job_reg.slot_r;
                sum_next = sum_reg + (job_reg.has_l ? SUM_BITS'(rdata) : '0);
                state_next = ST_RD_U;
            end
            ST_RD_U:
            begin
                raddr    = job_reg.slot_u;
                sum_next = sum_reg + (job_reg.has_r ? SUM_BITS'(rdata) : '0);
                state_next = ST_ACC_U;
            end
            ST_ACC_U:
            begin
                // upper read already issued, safe to overwrite its slot now
                ram_we     = job_reg.wr;
                sum_next   = sum_reg + (job_reg.has_u ? SUM_BITS'(rdata) : '0)
                                     + (job_reg.has_d ? SUM_BITS'(job_reg.pixel) : '0);
                state_next = job_reg.emit ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                prod_next  = PROD_BITS'(sum_reg) * PROD_BITS'(div.recip);
                shift_next = div.shift;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.smoothed  = PIX_BITS'(quot);
                    out_data_next.col       = job_reg.col;
                    out_data_next.row       = job_reg.row;
                    out_data_next.frame_end = job_reg.frame_end;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        shift_reg    <= shift_next;
        out_data_reg <= out_data_next;
    end

    a_pts_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC_U && job_reg.emit) |-> (pts == 3'd1 || pts >= 3'd3))
        else $error("neighbour count of two or zero on a result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !out_ready) |=> (state_reg == ST_OUT))
        else $error("result left the sequencer while output was stalled");

endmodule

`default_nettype wire

FILE: sv/cross_neighbour_average_filter.sv
`default_nettype none

// Five-point cross mean filter for a square 8-bit heightmap streamed in raster
// order. Each height item (op = pixel) of a frame returns the smoothed value of
// the pixel one row above it; the first row returns nothing. After the last
// pixel, one drain item (op = drain) per column returns the last row, the final
// one flagged with frame_end; then a new frame starts. Pixels after a full frame
// and drains outside the drain phase are swallowed. Writing image_width (byte 0
// of the APB port, 0 acts as 1, values above 1024 as 1024) restarts the frame;
// write it only while idle. The back end works one item at a time through
// the line store's single read port, four reads in sequence, and takes no new
// item until it is through with the last one. A four-item queue lets the
// input side run ahead of the back end. The line store has no clearing pass;
// its contents are only used after being written in the current frame.
module cross_neighbour_average_filter import cnaf_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,

    // pixel / drain items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire cnaf_in_t              in_data,

    // smoothed results
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output cnaf_out_t                  out_data
);

    logic [CFG_BITS-1:0]   width_reg, width_next;
    logic                  cfg_wr;
    logic [WIDTH_BITS-1:0] width_eff;

    logic                  push;
    cnaf_job_t             push_job;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_nonempty;
    cnaf_job_t             q_head;

    // Register file: only image_width. Writes land in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[PADDR_BITS-1:2] == REG_IMAGE_WIDTH);

    always_comb
    begin
        width_next = cfg_wr ? pwdata[CFG_BITS-1:0] : width_reg;
        prdata     = (paddr[PADDR_BITS-1:2] == REG_IMAGE_WIDTH) ? 32'(width_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else
        begin
            width_reg <= width_next;
        end
    end

    // clamped side length used by the position counters
    assign width_eff = eff_width(width_reg);

    // Front: tracks raster position, drops out-of-phase items, computes
    // ring-buffer slots and boundary flags for each item.
    cnaf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .width    (width_eff),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .job      (push_job),
        .q_full   (q_full)
    );

    cnaf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // Back: reads the neighbours from the two-row line store, writes the new
    // pixel, divides by the neighbour count and holds the result for output.
    cnaf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

FILE: test/cnaf_checker.sv
`timescale 1ns / 100ps

module cnaf_checker import cnaf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  cnaf_in_t              in_data,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  cnaf_out_t             out_data,

    output int unsigned           fail_count,
    output int unsigned           pending
);

    logic [CFG_BITS-1:0] width_reg;
    logic [PIX_BITS-1:0] heights [SLOT_DEPTH];
    int unsigned         taken;
    int unsigned         drained;
    bit                  in_drain;
    cnaf_out_t           smoothed_q [$];
    int unsigned         bad;

    function automatic int unsigned side();
        int unsigned w;
        w = width_reg;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    // Mean of position p and its in-bounds cross neighbors; the ring holds 2w pixels.
    function automatic cnaf_out_t cross_mean(int unsigned p, int unsigned w,
                                             bit has_down, int unsigned down);
        cnaf_out_t   r;
        int unsigned y;
        int unsigned x;
        int unsigned sum;
        int unsigned pts;
        y   = p / w;
        x   = p % w;
        sum = heights[p % (2 * w)];
        pts = 1;
        if (x > 0)
        begin
            sum += heights[(p - 1) % (2 * w)];
            pts++;
        end
        if (x + 1 < w)
        begin
            sum += heights[(p + 1) % (2 * w)];
            pts++;
        end
        if (y > 0)
        begin
            sum += heights[(p - w) % (2 * w)];
            pts++;
        end
        if (has_down)
        begin
            sum += down;
            pts++;
        end
        r.smoothed  = PIX_BITS'(sum / pts);
        r.col       = POS_BITS'(x);
        r.row       = POS_BITS'(y);
        r.frame_end = (p + 1 == w * w);
        return r;
    endfunction

    function automatic void take_item(cnaf_in_t it);
        int unsigned w;
        int unsigned total;
        w     = side();
        total = w * w;
        if (it.op == OP_PIXEL)
        begin
            // dropped while the last row is pending
            if (!in_drain && taken < total)
            begin
                if (taken >= w)
                    smoothed_q.push_back(cross_mean(taken - w, w, 1'b1, it.pixel));
                heights[taken % (2 * w)] = it.pixel;
                taken++;
                if (taken == total)
                begin
                    in_drain = 1'b1;
                    drained  = 0;
                end
            end
        end
        else if (in_drain && drained < w)
        begin
            smoothed_q.push_back(cross_mean(total - w + drained, w, 1'b0, 0));
            drained++;
            if (drained >= w)
            begin
                in_drain = 1'b0;
                drained  = 0;
                taken    = 0;
            end
        end
    endfunction

    function automatic void check_result(cnaf_out_t got);
        cnaf_out_t want;
        if (smoothed_q.size() == 0)
        begin
            bad++;
            if (bad <= 10)
                $display("%0t cnaf_checker: extra result smoothed %0d col %0d row %0d end %0b",
                         $realtime, got.smoothed, got.col, got.row, got.frame_end);
        end
        else
        begin
            want = smoothed_q.pop_front();
            if (got.smoothed !== want.smoothed || got.col !== want.col ||
                got.row !== want.row || got.frame_end !== want.frame_end)
            begin
                bad++;
                if (bad <= 10)
                begin
                    $write("%0t cnaf_checker: mismatch, expected smoothed %0d col %0d ",
                           $realtime, want.smoothed, want.col);
                    $write("row %0d end %0b, ", want.row, want.frame_end);
                    $display("got smoothed %0d col %0d row %0d end %0b",
                             got.smoothed, got.col, got.row, got.frame_end);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = WIDTH_RESET;
            taken     = 0;
            drained   = 0;
            in_drain  = 1'b0;
            bad       = 0;
            smoothed_q.delete();
        end
        else
        begin
            // results first: none can stem from an item taken at the same edge
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                take_item(in_data);
            if (psel && penable && pwrite && pready && paddr == {REG_IMAGE_WIDTH, 2'b00})
            begin
                width_reg = pwdata[CFG_BITS-1:0];
                taken     = 0;
                drained   = 0;
                in_drain  = 1'b0;
            end
        end
        fail_count <= bad;
        pending    <= smoothed_q.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cnaf_pkg::*;

    // stop the random part after this many well-formed items
    localparam int RANDOM_ITEMS  = 120;
    // a non-result item may still sit in the 4-deep queue
    localparam int SETTLE_CYCLES = 64;
    // receiver hold-off, long enough to fill the block and stall its input
    localparam int LONG_HOLD     = 300;

    // 3x3 frame: corners average 3 values, edges 4, the center 5 (center and its cross all 255)
    localparam logic [71:0] CROSS3 = {8'd0,   8'd255, 8'd0,
                                      8'd255, 8'd255, 8'd255,
                                      8'd1,   8'd255, 8'd254};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [PADDR_BITS-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    cnaf_in_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    cnaf_out_t             out_data;
    int unsigned           fail_count;
    int unsigned           pending;

    // idle pattern state of each side: calm stretches without gaps
    int unsigned           send_left = 0;
    bit                    send_calm = 1'b0;
    int unsigned           recv_left = 0;
    bit                    recv_calm = 1'b0;

    always #5 clk = ~clk;

    cross_neighbour_average_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    cnaf_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Random gap before the next item, or none during a calm stretch.
    function automatic int unsigned draw_gap(inout int unsigned left, inout bit calm);
        if (left == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(16, 64);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // Heights lean toward 0 and 255 to hit the sum extremes.
    function automatic logic [PIX_BITS-1:0] rand_height();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return PIX_BITS'($urandom_range(0, 255));
    endfunction

    task automatic offer(input logic op, input logic [PIX_BITS-1:0] pix);
        int unsigned gap;
        gap = draw_gap(send_left, send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_data.op    <= op;
        in_data.pixel <= pix;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_width(input logic [CFG_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IMAGE_WIDTH, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every expected result is in and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sends cut pixels of a w x w frame; a full frame is closed by w drains.
    // Stray items that the block must drop are mixed in now and then.
    task automatic run_frame(input int unsigned w, input int unsigned cut,
                             inout int unsigned count);
        int unsigned k;
        for (k = 0; k < cut; k++)
        begin
            // drain with no frame complete: dropped
            if ($urandom_range(0, 23) == 0)
                offer(OP_DRAIN, rand_height());
            offer(OP_PIXEL, rand_height());
        end
        count += cut;
        if (cut == w * w)
        begin
            // pixels beyond a full frame: dropped
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) offer(OP_PIXEL, rand_height());
            for (k = 0; k < w; k++)
            begin
                if ($urandom_range(0, 23) == 0)
                    offer(OP_PIXEL, rand_height());
                offer(OP_DRAIN, rand_height());
            end
            count += w;
            // drain after the frame closed: dropped
            if ($urandom_range(0, 5) == 0)
                offer(OP_DRAIN, rand_height());
        end
    endtask

    initial
    begin : stimulus
        int unsigned done_items;
        int unsigned scratch;
        int unsigned w;
        int unsigned k;

        done_items = 0;
        scratch    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width of 256: one row plus a few results
        run_frame(256, 256 + 6, scratch);
        settle();

        // directed: 3x3 frame, stray drain before it and stray pixel after it
        write_width(CFG_BITS'(3));
        offer(OP_DRAIN, 8'h5A);
        for (k = 0; k < 9; k++)
            offer(OP_PIXEL, CROSS3[71 - 8 * k -: 8]);
        offer(OP_PIXEL, 8'hA5);
        repeat (3) offer(OP_DRAIN, 8'h00);
        settle();

        // zero acts as width 1: single-value mean, result only on the drain
        write_width('0);
        offer(OP_PIXEL, 8'd200);
        offer(OP_DRAIN, 8'hFF);
        settle();

        write_width(CFG_BITS'(2));
        offer(OP_PIXEL, 8'hFF);
        offer(OP_PIXEL, 8'hFF);
        offer(OP_PIXEL, 8'hFF);
        offer(OP_PIXEL, 8'hFE);
        offer(OP_DRAIN, 8'h00);
        offer(OP_DRAIN, 8'hFF);
        settle();

        // widths beyond the maximum, frames left unfinished
        write_width('1);
        run_frame(MAX_WIDTH, MAX_WIDTH + 6, scratch);
        settle();
        write_width(CFG_BITS'(MAX_WIDTH + 1));
        run_frame(MAX_WIDTH, 30, scratch);
        settle();

        // random part: mostly complete frames at small widths
        while (done_items < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 10);
            write_width(CFG_BITS'(w));
            repeat ($urandom_range(1, 2)) run_frame(w, w * w, done_items);
            // a frame cut short; the next width write restarts it
            if ($urandom_range(0, 3) == 0)
                run_frame(w, $urandom_range(0, w * w - 1), done_items);
            settle();
        end

        settle();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Result side, with two long hold-offs to back the block up.
    initial
    begin : result_side
        int unsigned gap;
        int unsigned got;

        got = 0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(recv_left, recv_calm);
            if (got == 30 || got == 80)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            got++;
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
